// ===== hdl/actuator_command_supervisor_assert.svh =====
// Assertion macros for the actuator command supervisor RTL.
// Expects signals named clk and rst_n in the module that uses them.
`ifndef ACTUATOR_COMMAND_SUPERVISOR_ASSERT_SVH
`define ACTUATOR_COMMAND_SUPERVISOR_ASSERT_SVH

// Same-cycle implication, disabled while in reset
`define ACS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define ACS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/acs_pkg.sv =====
// Types and constants of the actuator command supervisor.
// Used by acs_table, acs_step and actuator_command_supervisor; no dependencies.
`default_nettype none

package acs_pkg;

    // Request opcodes
    typedef enum logic [1:0] {
        OP_START  = 2'd0,
        OP_REPORT = 2'd1,
        OP_POLL   = 2'd2,
        OP_UNUSED = 2'd3
    } opcode_t;

    // Operation status per actuator
    typedef enum logic [1:0] {
        STS_IDLE    = 2'd0,
        STS_WORKING = 2'd1,
        STS_OK      = 2'd2,
        STS_FAILED  = 2'd3
    } status_t;

    // Recommended behavior after a failure
    typedef enum logic [1:0] {
        ADV_OK          = 2'd0,
        ADV_DISABLE     = 2'd1,
        ADV_RETRY       = 2'd2,
        ADV_UNREACHABLE = 2'd3
    } advice_t;

    // Outcome reported back to the queue
    typedef enum logic [2:0] {
        OUT_PROGRESS = 3'd0,
        OUT_DONE     = 3'd1,
        OUT_DISABLED = 3'd2,
        OUT_RETRY    = 3'd3,
        OUT_IDLE     = 3'd4
    } outcome_t;

    // Sequencer states
    typedef enum logic {
        SQ_IDLE = 1'b0,
        SQ_EXEC = 1'b1
    } seq_state_t;

    // Send kinds
    localparam logic [1:0] SEND_NONE     = 2'd0;
    localparam logic [1:0] SEND_PRIMARY  = 2'd1;
    localparam logic [1:0] SEND_FALLBACK = 2'd2;

    // Report result codes
    localparam logic RES_DONE = 1'b0;

    // Failure reason codes
    localparam logic [3:0] RSN_OK           = 4'd0;
    localparam logic [3:0] RSN_OTHER        = 4'd1;
    localparam logic [3:0] RSN_TIMEOUT      = 4'd2;
    localparam logic [3:0] RSN_NOT_HERE     = 4'd3;
    localparam logic [3:0] RSN_NO_RESOURCES = 4'd4;
    localparam logic [3:0] RSN_CANCELED     = 4'd5;

    // Retry delay after reset, in ms
    localparam logic [15:0] RETRY_DELAY_RST = 16'd10;

    // Input request
    typedef struct packed {
        logic [1:0]  opcode;
        logic [3:0]  act_index;
        logic [31:0] now_ms;
        logic [15:0] timeout_ms;
        logic        has_fallback;
        logic        result_code;
        logic [3:0]  reason_code;
        logic [31:0] report_params;
    } in_t;

    // Result
    typedef struct packed {
        logic [3:0]  act_index_out;
        logic [1:0]  send_kind;
        logic        rejected;
        logic        advance_queue;
        logic        queue_error;
        logic [2:0]  last_outcome;
        logic [31:0] last_params_out;
        logic        is_disabled;
    } out_t;

    // Table entry with defined reset contents
    typedef struct packed {
        logic        disabled;
        status_t     status;
        advice_t     advice;
        outcome_t    outcome;
        logic [31:0] pending;
        logic [31:0] latched;
        logic        fallback;
    } entry_t;

    localparam entry_t ENTRY_RST = '{
        disabled: 1'b0,
        status:   STS_IDLE,
        advice:   ADV_OK,
        outcome:  OUT_IDLE,
        pending:  32'd0,
        latched:  32'd0,
        fallback: 1'b0
    };

    // Timing entry, written by a start before its contents are used
    typedef struct packed {
        logic [31:0] start_time;
        logic [15:0] op_timeout;
    } tim_t;

    // Write strobes from the step logic
    typedef struct packed {
        logic entry_we;
        logic tim_we;
        logic dl_we;
    } wr_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/actuator_command_supervisor.sv =====
// Actuator command supervisor. A request accepted into the request register starts
// its table read; its result is loaded into the output register when the sequencer
// commits it, later while the output is stalled. A new request is not taken until
// the previous one's table read, update and write-back are through. Reset: the
// sequencer, output valid, retry deadline and table valid bits clear at once (table
// entries read as reset, no clearing pass); retry delay returns to 10 ms.
`default_nettype none

module actuator_command_supervisor #(
    parameter int NUM_ACTUATORS = 16
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_stall,
    input  wire acs_pkg::in_t   in_data,
    output logic                out_valid,
    input  wire logic           out_stall,
    output acs_pkg::out_t       out_data,
    input  wire logic           cfg_we,
    input  wire logic [15:0]    cfg_wdata
);
    import acs_pkg::*;

    localparam int IDX_W = (NUM_ACTUATORS > 1) ? $clog2(NUM_ACTUATORS) : 1;

    `include "actuator_command_supervisor_assert.svh"

    seq_state_t  state_reg;
    seq_state_t  state_next;
    in_t         req_reg;
    logic        in_range_reg;
    logic [31:0] deadline_reg;
    logic [15:0] retry_delay_reg;
    logic        out_valid_reg;
    out_t        out_reg;

    logic        accept;
    logic        commit;
    logic        out_free;
    logic        rd_range;

    entry_t      rd_entry;
    tim_t        rd_tim;
    entry_t      entry_new;
    tim_t        tim_new;
    logic [31:0] deadline_new;
    wr_ctl_t     wr_ctl;
    out_t        result;

    assign rd_range = (32'(in_data.act_index) < 32'(NUM_ACTUATORS));
    assign out_free = !out_valid_reg || !out_stall;

    // Sequencer: read the entry, then update and deliver
    always_comb
    begin
        state_next = state_reg;
        in_stall   = 1'b1;
        accept     = 1'b0;
        commit     = 1'b0;
        unique case (state_reg)
            SQ_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    accept     = 1'b1;
                    state_next = SQ_EXEC;
                end
            end
            SQ_EXEC:
            begin
                if (out_free)
                begin
                    commit     = 1'b1;
                    state_next = SQ_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= SQ_IDLE;
            out_valid_reg   <= 1'b0;
            deadline_reg    <= 32'd0;
            retry_delay_reg <= RETRY_DELAY_RST;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= commit || (out_valid_reg && out_stall);
            if (commit && wr_ctl.dl_we)
            begin
                deadline_reg <= deadline_new;
            end
            if (cfg_we)
            begin
                retry_delay_reg <= cfg_wdata;
            end
        end
    end

    // Request and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg      <= in_data;
            in_range_reg <= rd_range;
        end
        if (commit)
        begin
            out_reg <= result;
        end
    end

    acs_table #(
        .NUM_ENTRIES (NUM_ACTUATORS)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (accept),
        .rd_addr  (IDX_W'(in_data.act_index)),
        .rd_entry (rd_entry),
        .rd_tim   (rd_tim),
        .entry_we (commit && wr_ctl.entry_we),
        .tim_we   (commit && wr_ctl.tim_we),
        .wr_addr  (IDX_W'(req_reg.act_index)),
        .wr_entry (entry_new),
        .wr_tim   (tim_new)
    );

    acs_step u_step (
        .req          (req_reg),
        .in_range     (in_range_reg),
        .entry        (rd_entry),
        .tim          (rd_tim),
        .deadline     (deadline_reg),
        .retry_delay  (retry_delay_reg),
        .entry_new    (entry_new),
        .tim_new      (tim_new),
        .deadline_new (deadline_new),
        .wr_ctl       (wr_ctl),
        .result       (result)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Checks
    `ACS_ASSERT_NEXT(a_accept_to_exec, in_valid && !in_stall, state_reg == SQ_EXEC,
        "accepted request did not enter update")
    `ACS_ASSERT_NEXT(a_commit_delivers, state_reg == SQ_EXEC && out_free,
        out_valid && state_reg == SQ_IDLE, "update did not load the result")
    `ACS_ASSERT_NOW(a_no_write_on_reject, commit && result.rejected,
        !wr_ctl.entry_we && !wr_ctl.tim_we && !wr_ctl.dl_we, "rejected request wrote state")
    `ACS_ASSERT_NOW(a_out_of_range,
        out_valid && (32'(out_data.act_index_out) >= 32'(NUM_ACTUATORS)),
        out_data.rejected && !out_data.is_disabled && out_data.send_kind == SEND_NONE,
        "out of range actuator not rejected")

endmodule

`default_nettype wire

// ===== hdl/acs_table.sv =====
// Per-actuator state table: entry memory with valid bits, timing memory without.
// Depends on acs_pkg.
`default_nettype none

module acs_table #(
    parameter int NUM_ENTRIES = 16,
    localparam int IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 rd_en,
    input  wire logic [IDX_W-1:0]     rd_addr,
    output acs_pkg::entry_t           rd_entry,
    output acs_pkg::tim_t             rd_tim,
    input  wire logic                 entry_we,
    input  wire logic                 tim_we,
    input  wire logic [IDX_W-1:0]     wr_addr,
    input  wire acs_pkg::entry_t      wr_entry,
    input  wire acs_pkg::tim_t        wr_tim
);
    import acs_pkg::*;

    entry_t entry_mem [NUM_ENTRIES];
    tim_t   tim_mem   [NUM_ENTRIES];

    logic [NUM_ENTRIES-1:0] vld_reg;
    logic                   rd_vld_reg;
    entry_t                 rd_entry_reg;
    tim_t                   rd_tim_reg;

    // Valid bits: an unwritten entry reads as its reset contents
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (entry_we)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    // Entry memory
    always_ff @(posedge clk)
    begin
        if (entry_we)
        begin
            entry_mem[wr_addr] <= wr_entry;
        end
        if (rd_en)
        begin
            rd_entry_reg <= entry_mem[rd_addr];
        end
    end

    // Timing memory
    always_ff @(posedge clk)
    begin
        if (tim_we)
        begin
            tim_mem[wr_addr] <= wr_tim;
        end
        if (rd_en)
        begin
            rd_tim_reg <= tim_mem[rd_addr];
        end
    end

    assign rd_entry = rd_vld_reg ? rd_entry_reg : ENTRY_RST;
    assign rd_tim   = rd_tim_reg;

endmodule

`default_nettype wire

// ===== hdl/acs_step.sv =====
// Update logic for one request: takes the read entry, forms the new entry,
// the write strobes, the retry deadline and the result. Depends on acs_pkg.
`default_nettype none

module acs_step (
    input  wire acs_pkg::in_t    req,
    input  wire logic            in_range,
    input  wire acs_pkg::entry_t entry,
    input  wire acs_pkg::tim_t   tim,
    input  wire logic [31:0]     deadline,
    input  wire logic [15:0]     retry_delay,
    output acs_pkg::entry_t      entry_new,
    output acs_pkg::tim_t        tim_new,
    output logic [31:0]          deadline_new,
    output acs_pkg::wr_ctl_t     wr_ctl,
    output acs_pkg::out_t        result
);
    import acs_pkg::*;

    entry_t     e;
    logic [1:0] send;
    logic       rej;
    logic       adv;
    logic       err;
    logic       timed_out;
    logic       retry_due;

    // Timeout sum kept at 33 bits so it never wraps
    assign timed_out = ({1'b0, req.now_ms}
                        >= ({1'b0, tim.start_time} + 33'(tim.op_timeout)));
    assign retry_due = (req.now_ms >= deadline);

    assign tim_new = '{start_time: req.now_ms, op_timeout: req.timeout_ms};

    always_comb
    begin
        e            = entry;
        send         = SEND_NONE;
        rej          = 1'b0;
        adv          = 1'b0;
        err          = 1'b0;
        deadline_new = deadline;
        wr_ctl       = '0;

        if (in_range)
        begin
            unique case (req.opcode)
                OP_START:
                begin
                    if (entry.disabled)
                    begin
                        rej = 1'b1;
                    end
                    else
                    begin
                        e.status        = STS_WORKING;
                        e.outcome       = OUT_PROGRESS;
                        e.fallback      = req.has_fallback;
                        send            = SEND_PRIMARY;
                        wr_ctl.entry_we = 1'b1;
                        wr_ctl.tim_we   = 1'b1;
                    end
                end
                OP_REPORT:
                begin
                    if (entry.status != STS_WORKING)
                    begin
                        rej = 1'b1;
                    end
                    else
                    begin
                        if (req.result_code == RES_DONE)
                        begin
                            e.status = STS_OK;
                        end
                        else
                        begin
                            e.status = STS_FAILED;
                            // Reason to advice; a repeat of timeout/not-here or of no-resources escalates to disable
                            unique case (req.reason_code)
                                RSN_OK, RSN_OTHER:
                                begin
                                end
                                RSN_TIMEOUT, RSN_NOT_HERE:
                                begin
                                    if (entry.advice == ADV_UNREACHABLE)
                                    begin
                                        e.disabled = 1'b1;
                                        e.advice   = ADV_DISABLE;
                                    end
                                    else
                                    begin
                                        e.advice = ADV_UNREACHABLE;
                                    end
                                end
                                RSN_NO_RESOURCES:
                                begin
                                    if (entry.advice == ADV_RETRY)
                                    begin
                                        e.disabled = 1'b1;
                                        e.advice   = ADV_DISABLE;
                                    end
                                    else
                                    begin
                                        e.advice = ADV_RETRY;
                                    end
                                end
                                RSN_CANCELED:
                                begin
                                    e.advice = ADV_RETRY;
                                end
                                default:
                                begin
                                    e.disabled = 1'b1;
                                    e.advice   = ADV_DISABLE;
                                end
                            endcase
                        end
                        e.pending       = req.report_params;
                        wr_ctl.entry_we = 1'b1;
                    end
                end
                OP_POLL:
                begin
                    if (entry.outcome != OUT_PROGRESS)
                    begin
                        adv = 1'b1;
                    end
                    else if (timed_out)
                    begin
                        e.disabled      = 1'b1;
                        e.outcome       = OUT_DISABLED;
                        err             = 1'b1;
                        adv             = 1'b1;
                        wr_ctl.entry_we = 1'b1;
                    end
                    else
                    begin
                        unique case (entry.status)
                            STS_FAILED:
                            begin
                                priority if (entry.advice == ADV_UNREACHABLE)
                                begin
                                    if (entry.fallback)
                                    begin
                                        e.status = STS_WORKING;
                                        send     = SEND_FALLBACK;
                                    end
                                    else
                                    begin
                                        e.outcome = OUT_RETRY;
                                        err       = 1'b1;
                                        adv       = 1'b1;
                                    end
                                end
                                else if (entry.advice == ADV_RETRY)
                                begin
                                    // Shared deadline: zero means not armed
                                    if (deadline == 32'd0)
                                    begin
                                        deadline_new = req.now_ms + 32'(retry_delay);
                                        wr_ctl.dl_we = 1'b1;
                                    end
                                    else if (retry_due)
                                    begin
                                        deadline_new = 32'd0;
                                        wr_ctl.dl_we = 1'b1;
                                        e.status     = STS_WORKING;
                                        send         = SEND_PRIMARY;
                                    end
                                end
                                else
                                begin
                                    e.disabled = 1'b1;
                                    e.outcome  = OUT_DISABLED;
                                    err        = 1'b1;
                                    adv        = 1'b1;
                                end
                                e.latched       = entry.pending;
                                wr_ctl.entry_we = 1'b1;
                            end
                            STS_OK:
                            begin
                                if (entry.advice == ADV_UNREACHABLE)
                                begin
                                    e.outcome = OUT_RETRY;
                                    err       = 1'b1;
                                end
                                else
                                begin
                                    e.outcome = OUT_DONE;
                                end
                                e.advice        = ADV_OK;
                                adv             = 1'b1;
                                e.latched       = entry.pending;
                                wr_ctl.entry_we = 1'b1;
                            end
                            STS_WORKING:
                            begin
                            end
                            STS_IDLE:
                            begin
                                err = 1'b1;
                                adv = 1'b1;
                            end
                        endcase
                    end
                end
                OP_UNUSED:
                begin
                    rej = 1'b1;
                end
            endcase
        end
    end

    assign entry_new = e;

    // Result: from the update for an actuator in the table, fixed values for one beyond it
    always_comb
    begin
        result.act_index_out = req.act_index;
        if (in_range)
        begin
            result.send_kind       = send;
            result.rejected        = rej;
            result.advance_queue   = adv;
            result.queue_error     = err;
            result.last_outcome    = e.outcome;
            result.last_params_out = e.latched;
            result.is_disabled     = e.disabled;
        end
        else
        begin
            result.send_kind       = SEND_NONE;
            result.rejected        = 1'b1;
            result.advance_queue   = 1'b0;
            result.queue_error     = 1'b0;
            result.last_outcome    = OUT_IDLE;
            result.last_params_out = 32'd0;
            result.is_disabled     = 1'b0;
        end
    end

endmodule

`default_nettype wire

// ===== tb/sv/tb_actuator_command_supervisor.sv =====
// Self-checking testbench for actuator_command_supervisor: directed and random requests
// against a per-actuator prediction kept in the bench. Depends on acs_pkg and the
// actuator_command_supervisor RTL only.
module tb_actuator_command_supervisor;
    timeunit 1ns;
    timeprecision 1ps;

    import acs_pkg::*;

    localparam int ACTUATORS = 16;
    localparam logic RES_FAILED = ~RES_DONE;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    in_t         in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    out_t        out_data;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_wdata = '0;

    // Predicted actuator table and shared retry timer
    logic        act_disabled [ACTUATORS] = '{default: 1'b0};
    status_t     act_status   [ACTUATORS] = '{default: STS_IDLE};
    advice_t     act_advice   [ACTUATORS] = '{default: ADV_OK};
    outcome_t    act_outcome  [ACTUATORS] = '{default: OUT_IDLE};
    logic [31:0] act_pending  [ACTUATORS] = '{default: 32'd0};
    logic [31:0] act_latched  [ACTUATORS] = '{default: 32'd0};
    logic [31:0] act_start    [ACTUATORS] = '{default: 32'd0};
    logic [15:0] act_timeout  [ACTUATORS] = '{default: 16'd0};
    logic        act_fallback [ACTUATORS] = '{default: 1'b0};
    logic [31:0] shared_deadline = 32'd0;
    logic [15:0] delay_setting = RETRY_DELAY_RST;

    out_t        replies_due [$];
    int          mismatches = 0;
    int          rx_hold = 0;
    bit          tx_idle = 1'b1;
    bit          rx_idle = 1'b1;
    logic [31:0] clock_ms = 32'd0;

    actuator_command_supervisor #(
        .NUM_ACTUATORS(ACTUATORS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Repeat of the same kind of failure escalates to a disable
    function automatic void escalate(logic [3:0] a, advice_t kind);
        if (act_advice[a] == kind)
        begin
            act_disabled[a] = 1'b1;
            act_advice[a] = ADV_DISABLE;
        end
        else
            act_advice[a] = kind;
    endfunction

    // Applies one request to the predicted table and returns the reply it gives
    function automatic out_t supervise_step(in_t r);
        out_t        o;
        logic [3:0]  a;
        logic [32:0] limit_ms;
        a = r.act_index;
        o = '0;
        o.act_index_out = r.act_index;
        case (r.opcode)
            OP_START:
                if (act_disabled[a])
                    o.rejected = 1'b1;
                else
                begin
                    act_status[a] = STS_WORKING;
                    act_outcome[a] = OUT_PROGRESS;
                    act_start[a] = r.now_ms;
                    act_timeout[a] = r.timeout_ms;
                    act_fallback[a] = r.has_fallback;
                    o.send_kind = SEND_PRIMARY;
                end
            OP_REPORT:
                if (act_status[a] != STS_WORKING)
                    o.rejected = 1'b1;
                else
                begin
                    if (r.result_code == RES_DONE)
                        act_status[a] = STS_OK;
                    else
                    begin
                        act_status[a] = STS_FAILED;
                        case (r.reason_code)
                            RSN_OK, RSN_OTHER: ;
                            RSN_TIMEOUT, RSN_NOT_HERE: escalate(a, ADV_UNREACHABLE);
                            RSN_NO_RESOURCES: escalate(a, ADV_RETRY);
                            RSN_CANCELED: act_advice[a] = ADV_RETRY;
                            default:
                            begin
                                act_disabled[a] = 1'b1;
                                act_advice[a] = ADV_DISABLE;
                            end
                        endcase
                    end
                    act_pending[a] = r.report_params;
                end
            OP_POLL:
            begin
                // deadline is formed one bit wider so it never wraps
                limit_ms = {1'b0, act_start[a]} + {17'd0, act_timeout[a]};
                if (act_outcome[a] != OUT_PROGRESS)
                    o.advance_queue = 1'b1;
                else if ({1'b0, r.now_ms} >= limit_ms)
                begin
                    act_disabled[a] = 1'b1;
                    act_outcome[a] = OUT_DISABLED;
                    o.queue_error = 1'b1;
                    o.advance_queue = 1'b1;
                end
                else
                    case (act_status[a])
                        STS_FAILED:
                        begin
                            if (act_advice[a] == ADV_UNREACHABLE)
                            begin
                                if (act_fallback[a])
                                begin
                                    act_status[a] = STS_WORKING;
                                    o.send_kind = SEND_FALLBACK;
                                end
                                else
                                begin
                                    act_outcome[a] = OUT_RETRY;
                                    o.queue_error = 1'b1;
                                    o.advance_queue = 1'b1;
                                end
                            end
                            else if (act_advice[a] == ADV_RETRY)
                            begin
                                // zero means not armed; the timer is shared by all
                                if (shared_deadline == 32'd0)
                                    shared_deadline = r.now_ms + {16'd0, delay_setting};
                                else if (r.now_ms >= shared_deadline)
                                begin
                                    shared_deadline = 32'd0;
                                    act_status[a] = STS_WORKING;
                                    o.send_kind = SEND_PRIMARY;
                                end
                            end
                            else
                            begin
                                act_disabled[a] = 1'b1;
                                act_outcome[a] = OUT_DISABLED;
                                o.queue_error = 1'b1;
                                o.advance_queue = 1'b1;
                            end
                            act_latched[a] = act_pending[a];
                        end
                        STS_OK:
                        begin
                            if (act_advice[a] == ADV_UNREACHABLE)
                            begin
                                act_outcome[a] = OUT_RETRY;
                                o.queue_error = 1'b1;
                            end
                            else
                                act_outcome[a] = OUT_DONE;
                            act_advice[a] = ADV_OK;
                            o.advance_queue = 1'b1;
                            act_latched[a] = act_pending[a];
                        end
                        STS_WORKING: ;
                        default:
                        begin
                            o.queue_error = 1'b1;
                            o.advance_queue = 1'b1;
                        end
                    endcase
            end
            default:
                o.rejected = 1'b1;
        endcase
        o.last_outcome = act_outcome[a];
        o.last_params_out = act_latched[a];
        o.is_disabled = act_disabled[a];
        return o;
    endfunction

    function automatic in_t random_request();
        in_t r;
        r.opcode = 2'($urandom_range(0, 3));
        r.act_index = 4'($urandom);
        r.now_ms = $urandom;
        r.timeout_ms = 16'($urandom);
        r.has_fallback = 1'($urandom);
        r.result_code = 1'($urandom);
        r.reason_code = 4'($urandom);
        r.report_params = $urandom;
        return r;
    endfunction

    function automatic in_t start_req(logic [3:0] act, logic [31:0] now, logic [15:0] tmo,
                                      logic fb);
        in_t r;
        r = '0;
        r.opcode = OP_START;
        r.act_index = act;
        r.now_ms = now;
        r.timeout_ms = tmo;
        r.has_fallback = fb;
        return r;
    endfunction

    function automatic in_t report_req(logic [3:0] act, logic res, logic [3:0] rsn,
                                       logic [31:0] params);
        in_t r;
        r = '0;
        r.opcode = OP_REPORT;
        r.act_index = act;
        r.result_code = res;
        r.reason_code = rsn;
        r.report_params = params;
        return r;
    endfunction

    function automatic in_t poll_req(logic [3:0] act, logic [31:0] now);
        in_t r;
        r = '0;
        r.opcode = OP_POLL;
        r.act_index = act;
        r.now_ms = now;
        return r;
    endfunction

    // Mostly the next natural request for an actuator, with random filler in unused
    // fields; some requests are pure noise
    function automatic in_t shape_request();
        in_t        r;
        logic [3:0] a;
        int unsigned pick;
        r = random_request();
        if ($urandom_range(0, 49) == 0)
            clock_ms += $urandom_range(0, 70000);
        else
            clock_ms += $urandom_range(0, 20);
        // steer toward actuators that still take work
        a = 4'($urandom_range(0, ACTUATORS - 1));
        repeat (3)
            if (act_disabled[a])
                a = 4'($urandom_range(0, ACTUATORS - 1));
        if ($urandom_range(0, 99) < 15)
            return r;
        r.act_index = a;
        r.now_ms = clock_ms;
        if (act_outcome[a] != OUT_PROGRESS)
        begin
            r.opcode = OP_START;
            r.timeout_ms = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(0, 40))
                                                         : 16'($urandom_range(2000, 65535));
            r.has_fallback = ($urandom_range(0, 4) != 0);
        end
        else if (act_status[a] == STS_WORKING && $urandom_range(0, 2) != 0)
        begin
            r.opcode = OP_REPORT;
            r.result_code = ($urandom_range(0, 4) < 3) ? RES_DONE : RES_FAILED;
            pick = $urandom_range(0, 99);
            if (pick < 35)
                r.reason_code = RSN_CANCELED;
            else if (pick < 55)
                r.reason_code = RSN_NO_RESOURCES;
            else if (pick < 75)
                r.reason_code = $urandom_range(0, 1) ? RSN_TIMEOUT : RSN_NOT_HERE;
        end
        else
            r.opcode = OP_POLL;
        return r;
    endfunction

    // Offers one request, waits for it to be taken, then records its reply
    task automatic send_request(input in_t r);
        int gap;
        gap = tx_idle ? $urandom_range(0, 17) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= r;
        do
            @(posedge clk);
        while (in_stall);
        replies_due.push_back(supervise_step(r));
    endtask

    task automatic drain_replies();
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        while (replies_due.size() != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_retry_delay(input logic [15:0] value);
        drain_replies();
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        delay_setting = value;
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s expected %0h got %0h", $realtime, name, want, got);
        end
    endtask

    task automatic check_reply(input out_t got);
        out_t want;
        if (replies_due.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: reply for actuator %0d with none due", $realtime,
                         got.act_index_out);
            return;
        end
        want = replies_due.pop_front();
        compare_field("act_index_out", 32'(want.act_index_out), 32'(got.act_index_out));
        compare_field("send_kind", 32'(want.send_kind), 32'(got.send_kind));
        compare_field("rejected", 32'(want.rejected), 32'(got.rejected));
        compare_field("advance_queue", 32'(want.advance_queue), 32'(got.advance_queue));
        compare_field("queue_error", 32'(want.queue_error), 32'(got.queue_error));
        compare_field("last_outcome", 32'(want.last_outcome), 32'(got.last_outcome));
        compare_field("last_params_out", want.last_params_out, got.last_params_out);
        compare_field("is_disabled", 32'(want.is_disabled), 32'(got.is_disabled));
    endtask

    // Reply side: random or requested stall before each reply, then check it
    initial
    begin : reply_receiver
        int hold;
        forever
        begin
            if (rx_hold > 0)
            begin
                hold = rx_hold;
                rx_hold = 0;
            end
            else
                hold = rx_idle ? $urandom_range(0, 17) : 0;
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (out_valid !== 1'b1);
            check_reply(out_data);
        end
    end

    // Field extremes, every opcode and the corner paths of the poll logic
    task automatic test_directed_sequences();
        in_t r;
        // normal completion on actuator 0, then stray requests
        send_request(start_req(4'd0, 32'd0, 16'hFFFF, 1'b1));
        send_request(poll_req(4'd0, 32'd5));
        send_request(report_req(4'd0, RES_DONE, RSN_OK, 32'hFFFF_FFFF));
        send_request(poll_req(4'd0, 32'd6));
        send_request(poll_req(4'd0, 32'd7));
        send_request(report_req(4'd0, RES_FAILED, RSN_OTHER, 32'h0000_0001));
        r = poll_req(4'd0, 32'd8);
        r.opcode = OP_UNUSED;
        send_request(r);
        // top index and top time: timeout sum must not wrap; unreachable twice
        send_request(start_req(4'd15, 32'hFFFF_FFFF, 16'hFFFF, 1'b1));
        send_request(report_req(4'd15, RES_FAILED, RSN_TIMEOUT, 32'hA5A5_0F0F));
        send_request(poll_req(4'd15, 32'hFFFF_FFFF));
        send_request(report_req(4'd15, RES_FAILED, RSN_NOT_HERE, 32'h5A5A_F0F0));
        send_request(poll_req(4'd15, 32'hFFFF_FFFF));
        send_request(start_req(4'd15, 32'd0, 16'd1, 1'b0));
        // zero timeout expires on the first poll
        send_request(start_req(4'd1, 32'd100, 16'd0, 1'b0));
        send_request(poll_req(4'd1, 32'd100));
        // retry after the shared delay, then a canceled failure
        send_request(start_req(4'd2, 32'd1000, 16'd60000, 1'b0));
        send_request(report_req(4'd2, RES_FAILED, RSN_NO_RESOURCES, 32'h1234_5678));
        send_request(poll_req(4'd2, 32'd1001));
        send_request(poll_req(4'd2, 32'd1011));
        send_request(report_req(4'd2, RES_FAILED, RSN_CANCELED, 32'h8765_4321));
        // a new start keeps the retry advice, so a second shortage disables
        send_request(start_req(4'd2, 32'd3000, 16'd1000, 1'b1));
        send_request(report_req(4'd2, RES_FAILED, RSN_NO_RESOURCES, 32'hDEAD_BEEF));
        send_request(poll_req(4'd2, 32'd3001));
        // failure that leaves advice ok is treated as disable
        send_request(start_req(4'd3, 32'd2000, 16'd500, 1'b1));
        send_request(report_req(4'd3, RES_FAILED, RSN_OTHER, 32'h0F0F_0F0F));
        send_request(poll_req(4'd3, 32'd2100));
    endtask

    // With no delay a deadline at time zero reads as unarmed and is armed again
    task automatic test_zero_retry_delay();
        write_retry_delay(16'd0);
        send_request(start_req(4'd8, 32'd0, 16'd100, 1'b0));
        send_request(report_req(4'd8, RES_FAILED, RSN_CANCELED, 32'h0000_FFFF));
        send_request(poll_req(4'd8, 32'd0));
        send_request(poll_req(4'd8, 32'd3));
        send_request(poll_req(4'd8, 32'd3));
    endtask

    // Longest delay with the time base crossing the 32-bit wrap
    task automatic test_retry_delay_wrap();
        write_retry_delay(16'hFFFF);
        clock_ms = 32'hFFFF_FC00;
        repeat (250) send_request(shape_request());
    endtask

    // Receiver holds off long enough to back the block up into its input
    task automatic test_output_backpressure();
        write_retry_delay(16'($urandom_range(1, 65534)));
        tx_idle = 1'b0;
        rx_hold = 400;
        repeat (40) send_request(shape_request());
        tx_idle = 1'b1;
        drain_replies();
    endtask

    task automatic test_random_traffic();
        write_retry_delay(16'($urandom_range(1, 200)));
        repeat (400) send_request(shape_request());
    endtask

    // Back-to-back requests with the reply side never stalling
    task automatic test_unthrottled_traffic();
        write_retry_delay(RETRY_DELAY_RST);
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        repeat (180) send_request(shape_request());
        drain_replies();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    initial
    begin : test_sequence
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_sequences();
        test_zero_retry_delay();
        test_retry_delay_wrap();
        test_output_backpressure();
        test_random_traffic();
        test_unthrottled_traffic();
        drain_replies();
        if (mismatches == 0 && replies_due.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin : watchdog
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
